// ----- rtl/core/msq_pkg.sv -----
// Shared types and constants for the maximal square search unit.
// Holds field widths, register map and the per-cell control struct.
// No dependencies.
package msq_pkg;

  localparam int SIDE_W       = 11;
  localparam int AREA_W       = 21;
  localparam int MAX_COLS_DEF = 1024;
  localparam int PADDR_W      = 2;
  localparam int PDATA_W      = 32;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam side_t ROW_LEN_RST = side_t'(1024);
  localparam area_t AREA_MAX    = '1;

  // Register map (byte addresses)
  localparam logic [PADDR_W-1:0] REG_ROW_LENGTH = 2'd0;

  // Control that travels with a cell from the read stage to the update stage
  typedef struct packed {
    logic is_set;     // cell value, 1 means set
    logic first_row;  // line store holds no row yet
    logic fwd;        // up size comes from the previous cell's write
  } msq_ctl_t;

endpackage

// ----- rtl/core/maximal_square_search_unit.sv -----
// Maximal square search unit: streams a binary matrix, one cell per item.
// An end-of-matrix item passes the update stage, then sets out_valid_o.
// Throughput: one item per cycle, set by the single line-store read per cell;
// input stalls only while an end-of-matrix item meets a result not yet taken.
// Reset clears the column, row and best-size tracking and sets row_length to
// 1024; the line store is not cleared and holds nothing meaningful until written.
module maximal_square_search_unit #(
  parameter int MAX_COLS = msq_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Cell input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cell_is_one_i,
  input  logic                         end_of_matrix_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output msq_pkg::side_t               max_side_o,
  output msq_pkg::area_t               max_area_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msq_pkg::PADDR_W-1:0]  paddr,
  input  logic [msq_pkg::PDATA_W-1:0]  pwdata,
  output logic [msq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import msq_pkg::*;

  localparam int    CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int    CMPW     = ((CW + 1) > SIDE_W) ? (CW + 1) : SIDE_W;
  localparam int    CAP_INT  = (MAX_COLS > 2047) ? 2047 : MAX_COLS;
  localparam side_t SIDE_CAP = side_t'(CAP_INT);
  localparam logic [CMPW-1:0] LEN_MAX = CMPW'(MAX_COLS);

  // Configuration
  side_t               row_length_q;
  logic                cfg_wr;

  // Read stage state
  logic [CW-1:0]       col_q, col_d;
  logic                first_row_q, first_row_d;
  logic [CMPW-1:0]     len_eff;
  logic [CMPW-1:0]     col_next;
  logic                wrap;
  logic                accept;

  // Update stage
  logic                s1_valid_q, s1_valid_d;
  logic [CW-1:0]       s1_col_q;
  msq_ctl_t            s1_ctl_q;
  logic                s1_wrap_q;
  logic                s1_eom_q;
  logic                s1_adv;
  side_t               fwd_data_q;
  side_t               left_q, left_d;
  side_t               diag_q, diag_d;
  side_t               best_q, best_d;
  side_t               best_new;
  side_t               up;
  side_t               size;
  side_t               ram_rdata;

  // Output register
  logic                out_valid_q, out_valid_d;
  side_t               out_side_q;
  logic                out_load;
  logic [2*SIDE_W-1:0] prod;

  // Register write and read-back
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LEN_RST;
    end else if (cfg_wr && (paddr == REG_ROW_LENGTH)) begin
      row_length_q <= pwdata[SIDE_W-1:0];
    end
  end

  assign prdata = (paddr == REG_ROW_LENGTH) ? PDATA_W'(row_length_q) : '0;

  // Clamp row length into 1..MAX_COLS and detect end of row
  always_comb begin
    if (row_length_q == '0) begin
      len_eff = CMPW'(1);
    end else if (CMPW'(row_length_q) > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = CMPW'(row_length_q);
    end
    col_next = CMPW'(col_q) + CMPW'(1);
    wrap     = (col_next >= len_eff);
  end

  // Handshake: take a cell whenever the update stage is free or draining
  assign s1_adv     = s1_valid_q & (~s1_eom_q | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign accept     = in_valid_i & in_ready_o;

  // Advance column and row tracking on each accepted item
  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (accept) begin
      if (end_of_matrix_i) begin
        col_d       = '0;
        first_row_d = 1'b1;
      end else if (wrap) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d = col_next[CW-1:0];
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  // Capture the cell for the update stage; flag a same-entry overlap
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q           <= col_q;
      s1_ctl_q.is_set    <= cell_is_one_i;
      s1_ctl_q.first_row <= first_row_q;
      s1_ctl_q.fwd       <= s1_valid_q & (s1_col_q == col_q);
      s1_wrap_q          <= wrap;
      s1_eom_q           <= end_of_matrix_i;
      fwd_data_q         <= size;
    end
  end

  // Line store of previous-row sizes
  msq_ram #(
    .WIDTH (SIDE_W),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (size),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // Recurrence for the cell in the update stage
  msq_update u_update (
    .ctl_i      (s1_ctl_q),
    .up_ram_i   (ram_rdata),
    .fwd_data_i (fwd_data_q),
    .left_i     (left_q),
    .diag_i     (diag_q),
    .side_cap_i (SIDE_CAP),
    .up_o       (up),
    .size_o     (size)
  );

  // Update neighbor sizes and the running best
  always_comb begin
    best_new = (size > best_q) ? size : best_q;
    left_d   = left_q;
    diag_d   = diag_q;
    best_d   = best_q;
    if (s1_adv) begin
      if (s1_eom_q || s1_wrap_q) begin
        left_d = '0;
        diag_d = '0;
      end else begin
        left_d = size;
        diag_d = up;
      end
      best_d = s1_eom_q ? '0 : best_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      diag_q <= '0;
      best_q <= '0;
    end else begin
      left_q <= left_d;
      diag_q <= diag_d;
      best_q <= best_d;
    end
  end

  // Hold the result until taken
  assign out_load = s1_adv & s1_eom_q;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_side_q <= best_new;
    end
  end

  // Area from the registered side, saturated to the field width
  assign prod = out_side_q * out_side_q;

  always_comb begin
    if (prod > (2*SIDE_W)'(AREA_MAX)) begin
      max_area_o = AREA_MAX;
    end else begin
      max_area_o = prod[AREA_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_side_o  = out_side_q;

endmodule

// ----- rtl/core/msq_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the line store of previous-row square sizes. No dependencies.
module msq_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a same-address read returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/msq_update.sv -----
// Square-size recurrence for one cell: picks the up size, takes the
// three-way minimum and adds one with saturation; a clear cell gives zero. Depends on msq_pkg.
module msq_update (
  input  msq_pkg::msq_ctl_t ctl_i,
  input  msq_pkg::side_t    up_ram_i,
  input  msq_pkg::side_t    fwd_data_i,
  input  msq_pkg::side_t    left_i,
  input  msq_pkg::side_t    diag_i,
  input  msq_pkg::side_t    side_cap_i,
  output msq_pkg::side_t    up_o,
  output msq_pkg::side_t    size_o
);
  import msq_pkg::*;

  side_t             up;
  side_t             min_ul;
  side_t             min_all;
  logic [SIDE_W:0]   sum;

  // Select up size: zero on the first row, bypass on a same-entry overlap
  always_comb begin
    if (ctl_i.first_row) begin
      up = '0;
    end else if (ctl_i.fwd) begin
      up = fwd_data_i;
    end else begin
      up = up_ram_i;
    end
  end

  // Take minimum of up, left and diagonal, then add one and saturate
  always_comb begin
    min_ul  = (left_i < up) ? left_i : up;
    min_all = (diag_i < min_ul) ? diag_i : min_ul;
    sum     = {1'b0, min_all} + {{SIDE_W{1'b0}}, 1'b1};
    if (!ctl_i.is_set) begin
      size_o = '0;
    end else if (sum > {1'b0, side_cap_i}) begin
      size_o = side_cap_i;
    end else begin
      size_o = sum[SIDE_W-1:0];
    end
  end

  assign up_o = up;

endmodule

// ----- tb/maximal_square_search_unit_tb.sv -----
// Testbench for maximal_square_search_unit: a directed table, then random phases of matrices.
// It predicts each result from its own line store and size tracking and checks the result
// side and area. Depends on msq_pkg and maximal_square_search_unit.
module maximal_square_search_unit_tb;
  import msq_pkg::*;

  localparam int COLS        = MAX_COLS_DEF;
  localparam int LATENCY     = 2;
  localparam int WATCHDOG    = 4000;
  localparam int HOLD_CYCLES = 250;
  localparam int RAND_ITEMS  = 600;
  localparam int RAND_MATS   = 50;
  localparam int DIR_ROWS    = 23;
  localparam side_t SIDE_CAP = side_t'(COLS);

  typedef struct {
    side_t side;
    area_t area;
  } square_t;

  typedef struct {
    logic [PDATA_W-1:0] len;    // row_length to hold while the item is sent
    logic               is_set;
    logic               eom;
    bit                 typed;  // result below is known by inspection
    side_t              side;
    area_t              area;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               cell_is_one_i;
  logic               end_of_matrix_i;
  logic               out_valid_o;
  logic               out_ready_i;
  side_t              max_side_o;
  area_t              max_area_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  maximal_square_search_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Square-size tracking that mirrors the block
  side_t              line_store [COLS];
  bit                 stored     [COLS];
  side_t              left_sz, diag_sz, best_sz;
  int unsigned        col_idx;
  bit                 top_row;
  logic [SIDE_W-1:0]  row_len_reg = ROW_LEN_RST;

  square_t            square_q [$];
  int                 mismatches, results_seen, cells_sent, mats_sent, cfg_writes, mid_changes;
  int                 idle_cycles;
  bit                 hold_req, calm;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    // one set cell and one clear cell at the reset row length
    '{1024, 1, 1, 1, 1, 1},
    '{1024, 0, 1, 1, 0, 0},
    // 2x2 of ones
    '{2, 1, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0}, '{2, 1, 1, 1, 2, 4},
    // 2x2 with one hole
    '{2, 1, 0, 0, 0, 0}, '{2, 0, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0}, '{2, 1, 1, 0, 0, 0},
    // 3x3 of ones
    '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0},
    '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0}, '{3, 1, 0, 0, 0, 0},
    '{3, 1, 1, 1, 3, 9},
    // zero length acts as one column
    '{0, 1, 0, 0, 0, 0}, '{0, 1, 0, 0, 0, 0}, '{0, 1, 1, 1, 1, 1},
    // all register bits set, clamped to the column limit
    '{2047, 1, 1, 1, 1, 1}
  };

  function automatic void clear_matrix();
    left_sz = '0;
    diag_sz = '0;
    best_sz = '0;
    col_idx = 0;
    top_row = 1'b1;
  endfunction

  function automatic int unsigned active_len();
    int unsigned n;
    n = row_len_reg;
    if (n == 0) n = 1;
    if (n > COLS) n = COLS;
    return n;
  endfunction

  // Advance the size recurrence by one cell; return 1 when it closes a matrix
  function automatic bit step_cell(input logic c, input logic e, output square_t sq);
    int unsigned len, cc;
    side_t       up, m, sz;
    logic [31:0] ar;
    len = active_len();
    cc  = (col_idx >= COLS) ? COLS - 1 : col_idx;
    up  = top_row ? side_t'(0) : line_store[cc];
    if (c) begin
      m = up;
      if (left_sz < m) m = left_sz;
      if (diag_sz < m) m = diag_sz;
      sz = (m >= SIDE_CAP) ? SIDE_CAP : m + side_t'(1);
    end else begin
      sz = '0;
    end
    line_store[cc] = sz;
    stored[cc]     = 1'b1;
    diag_sz        = up;
    left_sz        = sz;
    if (sz > best_sz) best_sz = sz;
    if (cc + 1 >= len) begin
      col_idx = 0;
      top_row = 1'b0;
      left_sz = '0;
      diag_sz = '0;
    end else begin
      col_idx = cc + 1;
    end
    sq.side = '0;
    sq.area = '0;
    if (!e) return 1'b0;
    ar = 32'(best_sz) * 32'(best_sz);
    if (ar > 32'(AREA_MAX)) ar = 32'(AREA_MAX);
    sq.side = best_sz;
    sq.area = area_t'(ar);
    clear_matrix();
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Offer one cell and hold it until accepted; queue the square it closes
  task automatic put_cell(input logic c, input logic e, input bit typed,
                          input side_t side, input area_t area);
    square_t sq;
    in_valid_i      <= 1'b1;
    cell_is_one_i   <= c;
    end_of_matrix_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    if (step_cell(c, e, sq)) begin
      if (typed) begin
        sq.side = side;
        sq.area = area;
      end
      square_q = {square_q, sq};
      mats_sent++;
    end
    cells_sent++;
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 17)) @(posedge clk_i);
  endtask

  // One APB transfer: setup, access, then return to idle
  task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_ROW_LENGTH;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_row_length();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== PDATA_W'(row_len_reg))
      note_mismatch($sformatf("row_length readback: expected %0d, got %0d", row_len_reg, rd));
  endtask

  // Drain all pending squares, let the pipeline settle, then write row_length
  task automatic set_row_length(input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] unused;
    in_valid_i <= 1'b0;
    while (square_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    apb_access(1'b1, val, unused);
    row_len_reg = val[SIDE_W-1:0];
    cfg_writes++;
    check_row_length();
  endtask

  // Result receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result against the oldest pending square
  always @(posedge clk_i) begin
    square_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (square_q.size() == 0) begin
        note_mismatch($sformatf("result with none pending: side %0d area %0d",
                                max_side_o, max_area_o));
      end else begin
        want = square_q.pop_front();
        if (max_side_o !== want.side)
          note_mismatch($sformatf("max_side: expected %0d, got %0d", want.side, max_side_o));
        if (max_area_o !== want.area)
          note_mismatch($sformatf("max_area: expected %0d, got %0d", want.area, max_area_o));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned        phase, eff, cells, pct, n_mats, mid_at, hi, grow_max, k;
    bit                 gaps;
    logic [PDATA_W-1:0] wval;
    clear_matrix();
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cell_is_one_i   <= 1'b0;
    end_of_matrix_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_row_length();

    // Directed table
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].len[SIDE_W-1:0] != row_len_reg) set_row_length(dir_tbl[i].len);
      put_cell(dir_tbl[i].is_set, dir_tbl[i].eom, dir_tbl[i].typed,
               dir_tbl[i].side, dir_tbl[i].area);
    end

    // Random phases, each set to a new row length; some matrices change it mid-matrix
    phase = 0;
    while (cells_sent < RAND_ITEMS + DIR_ROWS || mats_sent < RAND_MATS) begin
      calm = (cells_sent >= (RAND_ITEMS * 4) / 5 + DIR_ROWS);
      case (phase)
        0:       wval = 1;
        1:       wval = ($urandom() & 32'hFFFF_F800) | 32'h7FF;
        2:       wval = 0;
        3:       wval = 1025;
        4:       wval = 1024;
        5:       wval = 3;
        6:       wval = 1;
        default: begin
          wval = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          if ($urandom_range(0, 3) == 0) wval = wval | ($urandom() & 32'hFFFF_F800);
        end
      endcase
      set_row_length(wval);
      eff = active_len();
      if (phase == 6) begin
        // Long result hold-off while single-cell matrices keep coming
        hold_req = 1'b1;
        repeat (30) put_cell($urandom_range(0, 1), 1'b1, 1'b0, '0, '0);
      end else begin
        n_mats = (phase == 1) ? 1 : (eff > 64) ? $urandom_range(2, 4) : $urandom_range(2, 5);
        repeat (n_mats) begin
          gaps = ($urandom_range(0, 2) != 0);
          case ($urandom_range(0, 3))
            0:       pct = 50;
            1:       pct = 85;
            2:       pct = 97;
            default: pct = 100;
          endcase
          if (phase == 1)                      cells = $urandom_range(2, 60);
          else if (eff > 64)                   cells = $urandom_range(1, 40);
          else if ($urandom_range(0, 7) == 0)  cells = $urandom_range(1, 3 * eff);
          else                                 cells = $urandom_range(1, 5) * eff;
          mid_at = (eff <= 64 && cells > 1 && $urandom_range(0, 5) == 0) ?
                   $urandom_range(1, cells - 1) : 0;
          for (k = 0; k < cells; k++) begin
            if (mid_at != 0 && k == mid_at) begin
              // Shrink, or grow only over columns the line store already holds
              hi = 0;
              while (hi < COLS && stored[hi]) hi++;
              grow_max = (hi > eff + 16) ? eff + 16 : (hi > eff ? hi : eff);
              wval = $urandom_range(0, 1) ? $urandom_range(1, eff) : $urandom_range(eff, grow_max);
              set_row_length(wval);
              eff = active_len();
              mid_changes++;
            end
            put_cell($urandom_range(0, 99) < pct, k == cells - 1, 1'b0, '0, '0);
            if (gaps && !calm && $urandom_range(0, 7) == 0) idle_gap();
          end
        end
      end
      phase++;
    end

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (square_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY + 4) @(posedge clk_i);
    $display("Run covered %0d cells in %0d matrices over %0d phases, %0d results checked;",
             cells_sent, mats_sent, phase, results_seen);
    $display("%0d row_length writes incl. 0, 1025, 2047 and %0d mid-matrix changes.",
             cfg_writes, mid_changes);
    if (mismatches == 0 && square_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
